@@ rtl/euler_to_quaternion_assert.svh @@
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define E2Q_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay, disabled while reset is asserted.
`define E2Q_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ rtl/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared widths, CORDIC constants and data types.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int INNER_BITS  = 20;
    localparam int CORDIC_FRAC = 30;
    localparam int XW          = 33;
    localparam int ZW          = 34;
    localparam int IW          = INNER_BITS + 2;
    localparam int PW          = 2 * IW;
    localparam int SPLIT       = IW - 1;
    localparam int HW          = PW - SPLIT;
    localparam int HCW         = HW + IW;
    localparam int LCW         = 2 * IW;
    localparam int TW          = 3 * IW;
    localparam int SW          = TW + 1;
    localparam int TRIG_CUT    = CORDIC_FRAC - INNER_BITS;
    localparam int MIX_STAGES  = 6;
    localparam int ATAN_COUNT  = 24;

    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
    localparam logic signed [XW-1:0] TRIG_HALF   = XW'(1) <<< (TRIG_CUT - 1);

    localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_COUNT] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340757, 2670675, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef logic signed [XW-1:0] e2q_vec_t;
    typedef logic signed [ZW-1:0] e2q_ang_t;
    typedef logic signed [IW-1:0] e2q_inner_t;

    typedef struct packed {
        e2q_vec_t x;
        e2q_vec_t y;
        e2q_ang_t z;
    } e2q_rot_t;

    typedef struct packed {
        e2q_inner_t cp;
        e2q_inner_t sp;
        e2q_inner_t cr;
        e2q_inner_t sr;
        e2q_inner_t cy;
        e2q_inner_t sy;
    } e2q_trig_t;

endpackage

@@ rtl/e2q_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered rotation step applied to the pitch, roll and yaw lanes.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  e2q_pkg::e2q_rot_t [2:0] in_rot,
    output logic                    out_valid,
    output e2q_pkg::e2q_rot_t [2:0] out_rot
);
    import e2q_pkg::*;

    logic              valid_reg;
    e2q_rot_t [2:0]    rot_reg;
    e2q_rot_t [2:0]    rot_next;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        e2q_vec_t x_cur;
        e2q_vec_t y_cur;
        e2q_ang_t z_cur;
        e2q_vec_t dx;
        e2q_vec_t dy;

        assign x_cur = in_rot[k].x;
        assign y_cur = in_rot[k].y;
        assign z_cur = in_rot[k].z;
        assign dx    = y_cur >>> STEP;
        assign dy    = x_cur >>> STEP;

        always_comb
        begin
            if (!z_cur[ZW-1])
            begin
                rot_next[k].x = x_cur - dx;
                rot_next[k].y = y_cur + dy;
                rot_next[k].z = z_cur - ATAN_TABLE[STEP];
            end
            else
            begin
                rot_next[k].x = x_cur + dx;
                rot_next[k].y = y_cur - dy;
                rot_next[k].z = z_cur + ATAN_TABLE[STEP];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;

endmodule

@@ rtl/e2q_mixer.sv @@
// ----------------------------------------------------------------------------
// Quaternion mixer
// Rounds the half-angle cosines and sines and forms the four components
// from triple products, then rounds and saturates them.
// ----------------------------------------------------------------------------
module e2q_mixer #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  e2q_pkg::e2q_rot_t [2:0]          in_rot,
    output logic                             out_valid,
    output logic signed [FRACTION_BITS+1:0]  out_x,
    output logic signed [FRACTION_BITS+1:0]  out_y,
    output logic signed [FRACTION_BITS+1:0]  out_z,
    output logic signed [FRACTION_BITS+1:0]  out_w
);
    import e2q_pkg::*;

    localparam int OW = FRACTION_BITS + 2;
    localparam int SH = 3 * INNER_BITS - FRACTION_BITS;
    localparam int VW = SW - SH;
    localparam logic signed [SW-1:0] SUM_HALF = SW'(1) <<< (SH - 1);
    localparam logic signed [VW-1:0] ONE_V    = VW'(1) <<< FRACTION_BITS;

    logic [MIX_STAGES-1:0] valid_reg;

    e2q_inner_t            cos_next [3];
    e2q_inner_t            sin_next [3];
    e2q_trig_t             trig_reg;

    logic signed [PW-1:0]  pair_next [4];
    logic signed [PW-1:0]  pair_reg  [4];
    e2q_inner_t            cy_reg;
    e2q_inner_t            sy_reg;

    logic signed [HCW-1:0] hc_next [4];
    logic signed [HCW-1:0] hs_next [4];
    logic signed [LCW-1:0] lc_next [4];
    logic signed [LCW-1:0] ls_next [4];
    logic signed [HCW-1:0] hc_reg  [4];
    logic signed [HCW-1:0] hs_reg  [4];
    logic signed [LCW-1:0] lc_reg  [4];
    logic signed [LCW-1:0] ls_reg  [4];

    logic signed [TW-1:0]  tc_next [4];
    logic signed [TW-1:0]  ts_next [4];
    logic signed [TW-1:0]  tc_reg  [4];
    logic signed [TW-1:0]  ts_reg  [4];

    logic signed [SW-1:0]  sum_next [4];
    logic signed [SW-1:0]  sum_reg  [4];

    logic signed [OW-1:0]  q_next [4];
    logic signed [OW-1:0]  q_reg  [4];

    for (genvar k = 0; k < 3; k++) begin : g_round
        e2q_vec_t cx;
        e2q_vec_t sx;

        assign cx          = in_rot[k].x + TRIG_HALF;
        assign sx          = in_rot[k].y + TRIG_HALF;
        assign cos_next[k] = cx[TRIG_CUT+IW-1:TRIG_CUT];
        assign sin_next[k] = sx[TRIG_CUT+IW-1:TRIG_CUT];
    end

    // Pair order: sr*cp, cr*sp, cr*cp, sr*sp.
    assign pair_next[0] = trig_reg.sr * trig_reg.cp;
    assign pair_next[1] = trig_reg.cr * trig_reg.sp;
    assign pair_next[2] = trig_reg.cr * trig_reg.cp;
    assign pair_next[3] = trig_reg.sr * trig_reg.sp;

    for (genvar k = 0; k < 4; k++) begin : g_triple
        logic signed [HW-1:0] hi;
        logic signed [IW-1:0] lo;
        logic signed [OW-1:0] q_sat;
        logic signed [SW-1:0] r;
        logic signed [VW-1:0] v;

        assign hi         = $signed(pair_reg[k][PW-1:SPLIT]);
        assign lo         = $signed({1'b0, pair_reg[k][SPLIT-1:0]});
        assign hc_next[k] = hi * cy_reg;
        assign hs_next[k] = hi * sy_reg;
        assign lc_next[k] = lo * cy_reg;
        assign ls_next[k] = lo * sy_reg;

        assign tc_next[k] = (TW'(hc_reg[k]) <<< SPLIT) + TW'(lc_reg[k]);
        assign ts_next[k] = (TW'(hs_reg[k]) <<< SPLIT) + TW'(ls_reg[k]);

        assign r = sum_reg[k] + SUM_HALF;
        assign v = r[SW-1:SH];

        always_comb
        begin
            if (v > ONE_V)
            begin
                q_sat = ONE_V[OW-1:0];
            end
            else if (v < -ONE_V)
            begin
                q_sat = -ONE_V[OW-1:0];
            end
            else
            begin
                q_sat = v[OW-1:0];
            end
        end

        assign q_next[k] = q_sat;
    end

    assign sum_next[0] = SW'(tc_reg[0]) - SW'(ts_reg[1]);
    assign sum_next[1] = SW'(tc_reg[1]) + SW'(ts_reg[0]);
    assign sum_next[2] = SW'(ts_reg[2]) - SW'(tc_reg[3]);
    assign sum_next[3] = SW'(tc_reg[2]) + SW'(ts_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[MIX_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg.cp <= cos_next[LANE_PITCH];
        trig_reg.sp <= sin_next[LANE_PITCH];
        trig_reg.cr <= cos_next[LANE_ROLL];
        trig_reg.sr <= sin_next[LANE_ROLL];
        trig_reg.cy <= cos_next[LANE_YAW];
        trig_reg.sy <= sin_next[LANE_YAW];
        cy_reg      <= trig_reg.cy;
        sy_reg      <= trig_reg.sy;
        for (int k = 0; k < 4; k++)
        begin
            pair_reg[k] <= pair_next[k];
            hc_reg[k]   <= hc_next[k];
            hs_reg[k]   <= hs_next[k];
            lc_reg[k]   <= lc_next[k];
            ls_reg[k]   <= ls_next[k];
            tc_reg[k]   <= tc_next[k];
            ts_reg[k]   <= ts_next[k];
            sum_reg[k]  <= sum_next[k];
            q_reg[k]    <= q_next[k];
        end
    end

    assign out_valid = valid_reg[MIX_STAGES-1];
    assign out_x     = q_reg[0];
    assign out_y     = q_reg[1];
    assign out_z     = q_reg[2];
    assign out_w     = q_reg[3];

endmodule

@@ rtl/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// Euler to quaternion converter
// Converts pitch, roll and yaw binary angles to a unit quaternion through a
// chain of CORDIC cells followed by a pipelined triple-product mixer.
//
//   channel   handshake            payload
//   input     start, busy          pitch_angle, roll_angle, yaw_angle
//   output    done                 quat_x, quat_y, quat_z, quat_w
//
// A word is accepted in every cycle in which start is high; busy stays low.
// Each result passes one CORDIC cell per step, then the six mixer stages.
// Results are shown for one cycle with done and cannot be stalled.
// Reset clears all valid flags; words in flight are dropped.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ANGLE_BITS-1:0]    pitch_angle,
    input  logic signed [ANGLE_BITS-1:0]    roll_angle,
    input  logic signed [ANGLE_BITS-1:0]    yaw_angle,
    output logic                            done,
    output logic signed [FRACTION_BITS+1:0] quat_x,
    output logic signed [FRACTION_BITS+1:0] quat_y,
    output logic signed [FRACTION_BITS+1:0] quat_z,
    output logic signed [FRACTION_BITS+1:0] quat_w
);
    import e2q_pkg::*;

    localparam int ZSHIFT = 31 - ANGLE_BITS;

    logic                  accept;
    logic                  valid_chain [CORDIC_STEPS+1];
    e2q_rot_t [2:0]        rot_chain   [CORDIC_STEPS+1];
    logic [ANGLE_BITS-1:0] angle_in    [3];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign angle_in[LANE_PITCH] = pitch_angle;
    assign angle_in[LANE_ROLL]  = roll_angle;
    assign angle_in[LANE_YAW]   = yaw_angle;

    for (genvar k = 0; k < 3; k++) begin : g_seed
        assign rot_chain[0][k].x = CORDIC_GAIN;
        assign rot_chain[0][k].y = '0;
        assign rot_chain[0][k].z =
            {{(ZW-ANGLE_BITS){angle_in[k][ANGLE_BITS-1]}}, angle_in[k]} << ZSHIFT;
    end

    assign valid_chain[0] = accept;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        e2q_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_rot    (rot_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_rot   (rot_chain[i+1])
        );
    end

    e2q_mixer #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[CORDIC_STEPS]),
        .in_rot    (rot_chain[CORDIC_STEPS]),
        .out_valid (done),
        .out_x     (quat_x),
        .out_y     (quat_y),
        .out_z     (quat_z),
        .out_w     (quat_w)
    );

endmodule

@@ rtl/e2q_checker.sv @@
// ----------------------------------------------------------------------------
// Euler to quaternion port checker
// Checks latency and output range as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module e2q_checker #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14,
    parameter int CORDIC_STEPS  = 16
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic signed [ANGLE_BITS-1:0]    pitch_angle,
    input logic signed [ANGLE_BITS-1:0]    roll_angle,
    input logic signed [ANGLE_BITS-1:0]    yaw_angle,
    input logic                            done,
    input logic signed [FRACTION_BITS+1:0] quat_x,
    input logic signed [FRACTION_BITS+1:0] quat_y,
    input logic signed [FRACTION_BITS+1:0] quat_z,
    input logic signed [FRACTION_BITS+1:0] quat_w
);
    import e2q_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + MIX_STAGES;
    localparam int OW      = FRACTION_BITS + 2;
    localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< FRACTION_BITS;

    logic accept_seen;
    logic range_ok;

    assign accept_seen = start && !busy;
    assign range_ok    = (quat_x <= ONE_Q) && (quat_x >= -ONE_Q)
                      && (quat_y <= ONE_Q) && (quat_y >= -ONE_Q)
                      && (quat_z <= ONE_Q) && (quat_z >= -ONE_Q)
                      && (quat_w <= ONE_Q) && (quat_w >= -ONE_Q)
                      && (pitch_angle == pitch_angle) && (roll_angle == roll_angle)
                      && (yaw_angle == yaw_angle);

    `E2Q_ASSERT_DELAY(a_latency, clk, rst_n, accept_seen, LATENCY, done, "word result missing")
    `E2Q_ASSERT_IMPLY(a_no_extra, clk, rst_n, done, $past(accept_seen, LATENCY), "result without word")
    `E2Q_ASSERT_IMPLY(a_range, clk, rst_n, done, range_ok, "component beyond unit range")

endmodule

bind euler_to_quaternion e2q_checker #(
    .ANGLE_BITS    (ANGLE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
) u_e2q_checker (.*);

@@ tb/tb_euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// Euler to quaternion converter testbench
// Sends pitch, roll and yaw words to the converter through its start/busy
// handshake. A short directed set comes first, then random words with random
// idle gaps. A scoreboard predicts each quaternion with its own CORDIC and
// triple-product arithmetic, and compares it field by field with every
// result marked by done.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion;

    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STEPS  = 16;
    localparam int TRIG_FRAC     = 20;
    localparam int QW            = FRACTION_BITS + 2;
    localparam int PIPE_DEPTH    = CORDIC_STEPS + 6;
    localparam int RANDOM_WORDS  = 1800;

    localparam longint GAIN_START = 652032874;
    localparam longint ARCTAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340757, 2670675, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [QW-1:0]         comp_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } quat_t;

    class quat_scoreboard;
        quat_t pending_quats[$];
        int    mismatches;
        int    checked;
        int    saturated;

        function new();
            mismatches = 0;
            checked    = 0;
            saturated  = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ERROR: %s", $time, msg);
        endtask

        function longint round_down_to(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function void half_cos_sin(angle_t ang, output longint c, output longint s);
            longint zr;
            longint xr;
            longint yr;
            longint dx;
            longint dy;
            zr = longint'(ang) <<< (31 - ANGLE_BITS);
            xr = GAIN_START;
            yr = 0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
            begin
                dx = yr >>> i;
                dy = xr >>> i;
                if (zr >= 0)
                begin
                    xr = xr - dx;
                    yr = yr + dy;
                    zr = zr - ARCTAN_TURNS[i];
                end
                else
                begin
                    xr = xr + dx;
                    yr = yr - dy;
                    zr = zr + ARCTAN_TURNS[i];
                end
            end
            c = round_down_to(xr, 30 - TRIG_FRAC);
            s = round_down_to(yr, 30 - TRIG_FRAC);
        endfunction

        function comp_t clamp_component(longint sum);
            longint one;
            longint v;
            one = longint'(1) <<< FRACTION_BITS;
            v = round_down_to(sum, 3 * TRIG_FRAC - FRACTION_BITS);
            if (v > one)
                v = one;
            if (v < -one)
                v = -one;
            if (v == one || v == -one)
                saturated++;
            return comp_t'(v);
        endfunction

        function void note_word(angle_t pitch, angle_t roll, angle_t yaw);
            longint cp, sp, cr, sr, cy, sy;
            quat_t q;
            half_cos_sin(pitch, cp, sp);
            half_cos_sin(roll, cr, sr);
            half_cos_sin(yaw, cy, sy);
            q.x = clamp_component(sr * cp * cy - cr * sp * sy);
            q.y = clamp_component(cr * sp * cy + sr * cp * sy);
            q.z = clamp_component(cr * cp * sy - sr * sp * cy);
            q.w = clamp_component(cr * cp * cy + sr * sp * sy);
            pending_quats.push_back(q);
        endfunction

        task compare_field(string name, comp_t got, comp_t want);
            if (got !== want)
                report($sformatf("%s got %0d, predicted %0d", name, got, want));
        endtask

        task check_result(comp_t x, comp_t y, comp_t z, comp_t w);
            quat_t q;
            if (pending_quats.size() == 0)
            begin
                report("result arrived with no word pending");
                return;
            end
            q = pending_quats.pop_front();
            checked++;
            compare_field("quat_x", x, q.x);
            compare_field("quat_y", y, q.y);
            compare_field("quat_z", z, q.z);
            compare_field("quat_w", w, q.w);
        endtask
    endclass

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    angle_t pitch_angle;
    angle_t roll_angle;
    angle_t yaw_angle;
    logic   done;
    comp_t  quat_x;
    comp_t  quat_y;
    comp_t  quat_z;
    comp_t  quat_w;

    quat_scoreboard sb = new();
    int words_sent;

    euler_to_quaternion #(
        .ANGLE_BITS    (ANGLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .yaw_angle   (yaw_angle),
        .done        (done),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .quat_w      (quat_w)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(quat_x, quat_y, quat_z, quat_w);
    end

    task automatic send_word(angle_t p, angle_t r, angle_t y);
        @(negedge clk);
        start       <= 1'b1;
        pitch_angle <= p;
        roll_angle  <= r;
        yaw_angle   <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(p, r, y);
        words_sent++;
    endtask

    task automatic idle_for(int n);
        repeat (n)
        begin
            @(negedge clk);
            start       <= 1'b0;
            pitch_angle <= angle_t'($urandom);
            roll_angle  <= angle_t'($urandom);
            yaw_angle   <= angle_t'($urandom);
        end
    endtask

    function automatic angle_t rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return angle_t'($urandom_range(0, 127) - 64);
            1:       return angle_t'(-32768 + $urandom_range(0, 63));
            2:       return angle_t'(32767 - $urandom_range(0, 63));
            3:       return angle_t'(($urandom_range(0, 1) ? 16384 : -16384)
                                     + $urandom_range(0, 63) - 32);
            default: return angle_t'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int drain;
        int directed;
        rst_n       = 1'b0;
        start       = 1'b0;
        pitch_angle = '0;
        roll_angle  = '0;
        yaw_angle   = '0;
        words_sent  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        idle_for(2);

        send_word(0, 0, 0);
        send_word(-32768, -32768, -32768);
        send_word(32767, 32767, 32767);
        send_word(-32768, 0, 0);
        send_word(0, -32768, 0);
        send_word(0, 0, -32768);
        send_word(32767, 0, 0);
        send_word(0, 32767, 0);
        send_word(0, 0, 32767);
        send_word(16384, 0, 0);
        send_word(0, 16384, 0);
        send_word(0, 0, 16384);
        send_word(16384, 16384, 16384);
        send_word(-16384, -16384, -16384);
        send_word(1, -1, 1);
        send_word(-1, 1, -1);
        send_word(16'sh5555, 16'shAAAA, 16'sh5555);
        send_word(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_word(-32768, 32767, -32768);
        send_word(32767, -32768, 32767);
        send_word(8192, -8192, 24576);
        directed = words_sent;

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if ((n % 300) >= 60)
                idle_for(pick_gap());
            send_word(rand_angle(), rand_angle(), rand_angle());
        end
        idle_for(1);

        drain = 0;
        while (sb.pending_quats.size() > 0 && drain < 20 * PIPE_DEPTH)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (sb.pending_quats.size() > 0)
            sb.report($sformatf("%0d predicted quaternions never arrived",
                                sb.pending_quats.size()));

        $display("Drove %0d words (%0d directed, %0d random), checked %0d quaternions.",
                 words_sent, directed, words_sent - directed, sb.checked);
        $display("%0d predicted components sat at the +/-1.0 limit, %0d mismatches.",
                 sb.saturated, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_euler_to_quaternion: PASS");
        else
            $display("tb_euler_to_quaternion: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_euler_to_quaternion: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_mixer.sv
rtl/euler_to_quaternion.sv
rtl/e2q_checker.sv
tb/tb_euler_to_quaternion.sv
